// File: src/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: src/slcd_pkg.sv
// Shared constants and controller/datapath handshake types for the deframer.
// No dependencies.
package slcd_pkg;

    localparam int PAYLOAD_DEPTH = 64;
    localparam int IDX_W         = 6;
    localparam int LEN_W         = 7;

    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h55;
    localparam logic [7:0] MAX_LEN     = 8'(PAYLOAD_DEPTH);

    // controller -> datapath
    typedef struct packed {
        logic load_type;
        logic load_len;
        logic store_byte;
        logic start_emit;
        logic emit_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic sync1_hit;
        logic sync2_hit;
        logic len_ok;
        logic len_zero;
        logic fill_done;
        logic sum_match;
        logic emit_last;
        logic slot_free;
    } sts_t;

endpackage

// File: src/slcd_ifs.sv
// Valid/ready channel interfaces for received bytes and deframed results.
// Depends on slcd_pkg.
interface slcd_in_if;
    import slcd_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface slcd_out_if;
    import slcd_pkg::*;
    logic             valid;
    logic             ready;
    logic [7:0]       frame_type;
    logic [LEN_W-1:0] frame_length;
    logic             has_payload;
    logic [7:0]       data_byte;
    logic [IDX_W-1:0] data_index;
    logic             last;
    modport source (output valid, output frame_type, output frame_length,
                    output has_payload, output data_byte, output data_index,
                    output last, input ready);
    modport sink (input valid, input frame_type, input frame_length,
                  input has_payload, input data_byte, input data_index,
                  input last, output ready);
endinterface

// File: src/slcd_ctrl.sv
// Parser/replay state machine of the deframer.
// Depends on slcd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module slcd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  slcd_pkg::sts_t sts,
    output slcd_pkg::cmd_t cmd
);
    import slcd_pkg::*;

    localparam logic [2:0] ST_SYNC1 = 3'd0;
    localparam logic [2:0] ST_SYNC2 = 3'd1;
    localparam logic [2:0] ST_TYPE  = 3'd2;
    localparam logic [2:0] ST_LEN   = 3'd3;
    localparam logic [2:0] ST_DATA  = 3'd4;
    localparam logic [2:0] ST_SUM   = 3'd5;
    localparam logic [2:0] ST_PRIME = 3'd6;
    localparam logic [2:0] ST_EMIT  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign in_ready = (state_reg != ST_PRIME) && (state_reg != ST_EMIT);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_SYNC1:
            begin
                if (accept)
                begin
                    state_next = sts.sync1_hit ? ST_SYNC2 : ST_SYNC1;
                end
            end
            ST_SYNC2:
            begin
                if (accept)
                begin
                    state_next = sts.sync2_hit ? ST_TYPE : ST_SYNC1;
                end
            end
            ST_TYPE:
            begin
                if (accept)
                begin
                    cmd.load_type = 1'b1;
                    state_next    = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (accept)
                begin
                    if (!sts.len_ok)
                    begin
                        state_next = ST_SYNC1;
                    end
                    else
                    begin
                        cmd.load_len = 1'b1;
                        state_next   = sts.len_zero ? ST_SUM : ST_DATA;
                    end
                end
            end
            ST_DATA:
            begin
                if (accept)
                begin
                    cmd.store_byte = 1'b1;
                    if (sts.fill_done)
                    begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                if (accept)
                begin
                    if (sts.sum_match)
                    begin
                        cmd.start_emit = 1'b1;
                        state_next     = ST_PRIME;
                    end
                    else
                    begin
                        state_next = ST_SYNC1;
                    end
                end
            end
            ST_PRIME:
            begin
                // first store read in flight
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit_load = 1'b1;
                    if (sts.emit_last)
                    begin
                        state_next = ST_SYNC1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SYNC1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `ASSERT_IMPLIES(a_no_rx_in_replay, (state_reg == ST_PRIME) || (state_reg == ST_EMIT),
        !in_ready)
    `ASSERT_NEXT(a_replay_ends, (state_reg == ST_EMIT) && sts.slot_free && sts.emit_last,
        state_reg == ST_SYNC1)
    `ASSERT_IMPLIES(a_emit_only_in_replay, cmd.emit_load, state_reg == ST_EMIT)

endmodule

// File: src/slcd_dp.sv
// Deframer datapath: header registers, checksum, payload store, result register.
// Depends on slcd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module slcd_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [7:0]                  rx_byte,
    input  slcd_pkg::cmd_t              cmd,
    output slcd_pkg::sts_t              sts,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  out_type,
    output logic [slcd_pkg::LEN_W-1:0]  out_length,
    output logic                        out_has,
    output logic [7:0]                  out_data,
    output logic [slcd_pkg::IDX_W-1:0]  out_index,
    output logic                        out_last
);
    import slcd_pkg::*;

    logic [7:0]       held_type_reg;
    logic [LEN_W-1:0] held_len_reg;
    logic [LEN_W-1:0] fill_reg;
    logic [7:0]       sum_reg;
    logic [LEN_W-1:0] emit_reg;
    logic [LEN_W-1:0] emit_next;
    logic [7:0]       store_mem [PAYLOAD_DEPTH];
    logic [7:0]       rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_type_reg;
    logic [LEN_W-1:0] out_length_reg;
    logic             out_has_reg;
    logic [7:0]       out_data_reg;
    logic [IDX_W-1:0] out_index_reg;
    logic             out_last_reg;
    logic             len_empty;

    assign len_empty = (held_len_reg == '0);

    // status
    assign sts.sync1_hit = (rx_byte == SYNC_FIRST);
    assign sts.sync2_hit = (rx_byte == SYNC_SECOND);
    assign sts.len_ok    = (rx_byte <= MAX_LEN);
    assign sts.len_zero  = (rx_byte == 8'd0);
    assign sts.fill_done = ((fill_reg + LEN_W'(1)) >= held_len_reg);
    assign sts.sum_match = (rx_byte == sum_reg);
    assign sts.emit_last = len_empty || ((emit_reg + LEN_W'(1)) == held_len_reg);
    assign sts.slot_free = !out_valid_reg || out_ready;

    // look one entry ahead when a result is loaded so read data tracks emit_reg
    assign emit_next = cmd.start_emit ? '0 :
                       (cmd.emit_load ? emit_reg + LEN_W'(1) : emit_reg);
    assign rd_addr   = emit_next[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load_type)
        begin
            held_type_reg <= rx_byte;
        end
        if (cmd.load_len)
        begin
            held_len_reg <= rx_byte[LEN_W-1:0];
            fill_reg     <= '0;
            sum_reg      <= held_type_reg + rx_byte;
        end
        else if (cmd.store_byte)
        begin
            fill_reg <= fill_reg + LEN_W'(1);
            sum_reg  <= sum_reg + rx_byte;
        end
        emit_reg <= emit_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_byte)
        begin
            store_mem[fill_reg[IDX_W-1:0]] <= rx_byte;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    // result register
    always_comb
    begin
        if (cmd.emit_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            out_type_reg   <= held_type_reg;
            out_length_reg <= held_len_reg;
            out_has_reg    <= !len_empty;
            out_data_reg   <= len_empty ? 8'd0 : rd_data_reg;
            out_index_reg  <= len_empty ? '0 : emit_reg[IDX_W-1:0];
            out_last_reg   <= sts.emit_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_type   = out_type_reg;
    assign out_length = out_length_reg;
    assign out_has    = out_has_reg;
    assign out_data   = out_data_reg;
    assign out_index  = out_index_reg;
    assign out_last   = out_last_reg;

    `ASSERT_IMPLIES(a_load_into_free_slot, cmd.emit_load, !out_valid_reg || out_ready)
    `ASSERT_IMPLIES(a_store_in_range, cmd.store_byte, fill_reg < held_len_reg)
    `ASSERT_IMPLIES(a_replay_in_range, cmd.emit_load && !len_empty, emit_reg < held_len_reg)

endmodule

// File: src/sync_length_checksum_deframer_unit.sv
// Top level of the sync/length/checksum deframer: controller plus datapath.
// Depends on slcd_pkg, slcd_ifs (channel interfaces), slcd_ctrl and slcd_dp.
// Throughput: one received byte per cycle while parsing; input stalls during replay.
// After the checksum item the controller passes a prime state and an emit state; the
// first result is registered from the emit state, then one per cycle while the output slot is free.
// Replay holds the input off through the prime state, set by the single registered
// read port of the payload store, and the emit state. Reset (async, active low) returns
// the parser to the first-sync hunt and empties the result register; the payload store is not cleared.
module sync_length_checksum_deframer_unit (
    input  logic       clk,
    input  logic       rst_n,
    slcd_in_if.sink    in_ch,
    slcd_out_if.source out_ch
);
    import slcd_pkg::*;

    // Command/status between the parser state machine and the datapath.
    cmd_t cmd;
    sts_t sts;

    // Parser and replay sequencing. The state machine owns the input ready:
    // bytes are taken in every hunt/header/payload/checksum phase, and held
    // off while the stored payload is being replayed to the output.
    slcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Header capture, running 8-bit checksum, 64-entry payload store and
    // the output register. The output register decouples the two sides: a
    // finished item may wait there while the parser takes the next frame.
    slcd_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_byte    (in_ch.rx_byte),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_type   (out_ch.frame_type),
        .out_length (out_ch.frame_length),
        .out_has    (out_ch.has_payload),
        .out_data   (out_ch.data_byte),
        .out_index  (out_ch.data_index),
        .out_last   (out_ch.last)
    );

endmodule

// File: bench/slcd_frame_checker.sv
// Checker for the deframer: watches both channels, predicts result items from the
// received bytes and compares them in order. Depends on slcd_pkg and slcd_ifs.
module slcd_frame_checker (
    input  logic clk,
    input  logic rst_n,
    slcd_in_if   in_ch,
    slcd_out_if  out_ch,
    output int   mismatch_count,
    output int   beats_pending
);
    import slcd_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef enum logic [2:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        TAKE_TYPE,
        TAKE_LEN,
        TAKE_DATA,
        TAKE_SUM
    } parse_phase_e;

    typedef struct packed {
        logic [7:0]       frame_type;
        logic [LEN_W-1:0] frame_length;
        logic             has_payload;
        logic [7:0]       data_byte;
        logic [IDX_W-1:0] data_index;
        logic             last;
    } frame_beat_t;

    parse_phase_e     phase;
    logic [7:0]       held_type;
    logic [LEN_W-1:0] held_len;
    logic [6:0]       fill;
    logic [7:0]       sum;
    logic [7:0]       payload[PAYLOAD_DEPTH];
    frame_beat_t      beat_q[$];
    int               errors;

    // Advance the parser by one received byte; queue the frame's result items
    // when the checksum byte matches.
    task automatic absorb_byte(input logic [7:0] b);
        frame_beat_t beat;
        case (phase)
            HUNT_SECOND: phase = (b == SYNC_SECOND) ? TAKE_TYPE : HUNT_FIRST;
            TAKE_TYPE:
            begin
                held_type = b;
                phase     = TAKE_LEN;
            end
            TAKE_LEN:
            begin
                if (b > MAX_LEN)
                begin
                    phase = HUNT_FIRST;
                end
                else
                begin
                    held_len = b[LEN_W-1:0];
                    fill     = '0;
                    sum      = held_type + b;
                    phase    = (b != 8'd0) ? TAKE_DATA : TAKE_SUM;
                end
            end
            TAKE_DATA:
            begin
                if (fill < PAYLOAD_DEPTH)
                    payload[fill[IDX_W-1:0]] = b;
                fill = fill + 7'd1;
                sum  = sum + b;
                if (fill >= held_len)
                    phase = TAKE_SUM;
            end
            TAKE_SUM:
            begin
                if (b == sum)
                begin
                    if (held_len == '0)
                    begin
                        beat = '{held_type, held_len, 1'b0, 8'd0, '0, 1'b1};
                        beat_q.push_back(beat);
                    end
                    else
                    begin
                        for (int k = 0; k < int'(held_len); k++)
                        begin
                            beat = '{held_type, held_len, 1'b1, payload[k],
                                     IDX_W'(k), (k + 1 == int'(held_len))};
                            beat_q.push_back(beat);
                        end
                    end
                end
                phase = HUNT_FIRST;
            end
            default: phase = (b == SYNC_FIRST) ? HUNT_SECOND : HUNT_FIRST;
        endcase
    endtask

    task automatic match_result();
        frame_beat_t got;
        frame_beat_t want;
        got = '{out_ch.frame_type, out_ch.frame_length, out_ch.has_payload,
                out_ch.data_byte, out_ch.data_index, out_ch.last};
        if (beat_q.size() == 0)
        begin
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("unexpected result item: type %02h len %0d has %0d data %02h idx %0d last %0d",
                         got.frame_type, got.frame_length, got.has_payload,
                         got.data_byte, got.data_index, got.last);
        end
        else
        begin
            want = beat_q.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                begin
                    $display("result mismatch: expected type %02h len %0d has %0d data %02h idx %0d last %0d",
                             want.frame_type, want.frame_length, want.has_payload,
                             want.data_byte, want.data_index, want.last);
                    $display("                 actual   type %02h len %0d has %0d data %02h idx %0d last %0d",
                             got.frame_type, got.frame_length, got.has_payload,
                             got.data_byte, got.data_index, got.last);
                end
            end
        end
    endtask

    // Input bytes are absorbed before results are matched; a result never
    // leaves in the same cycle as the checksum byte that causes it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase     = HUNT_FIRST;
            held_type = '0;
            held_len  = '0;
            fill      = '0;
            sum       = '0;
            errors    = 0;
            beat_q.delete();
            mismatch_count <= 0;
            beats_pending  <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                absorb_byte(in_ch.rx_byte);
            if (out_ch.valid && out_ch.ready)
                match_result();
            mismatch_count <= errors;
            beats_pending  <= beat_q.size();
        end
    end

endmodule

// File: bench/tb.sv
// Top of the deframer testbench: clock, reset, byte stimulus, result-side stalls
// and the verdict. Depends on slcd_pkg, slcd_ifs, the deframer and slcd_frame_checker.
module tb;
    import slcd_pkg::*;

    localparam int CYCLE_LIMIT   = 100000;
    // Covers the replay of the longest frame, with margin on top.
    localparam int SETTLE_CYCLES = 100;
    localparam int PHASE_BYTES   = 16;

    logic clk;
    logic rst_n;
    int   send_idle_pct = 34;
    int   recv_idle_pct = 58;
    int   cycle_count   = 0;
    int   bytes_sent    = 0;
    int   mismatch_count;
    int   beats_pending;

    slcd_in_if  in_ch();
    slcd_out_if out_ch();

    sync_length_checksum_deframer_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    slcd_frame_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .mismatch_count (mismatch_count),
        .beats_pending  (beats_pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Result side: random stalls at the current idle rate.
    always @(posedge clk)
    begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: a hang or a lost handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sync_length_checksum_deframer_unit test failed");
            $finish;
        end
    end

    // One byte item. Valid stays high on return so back-to-back items need no
    // drop; a random gap lowers it first.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        bytes_sent++;
    endtask

    // Whole frame with random payload; a nonzero skew corrupts the checksum.
    task automatic send_frame(input logic [7:0] ftype, input int unsigned len,
                              input logic [7:0] sum_skew);
        logic [7:0] sum;
        logic [7:0] b;
        sum = ftype + 8'(len);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(ftype);
        send_byte(8'(len));
        for (int i = 0; i < int'(len); i++)
        begin
            b   = 8'($urandom);
            sum = sum + b;
            send_byte(b);
        end
        send_byte(sum + sum_skew);
    endtask

    // Hold the sender off until every predicted result has come out.
    task automatic drain();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (beats_pending != 0);
    endtask

    // Mostly short payloads; a few at full depth.
    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(0, 6);
        else if (r < 93)
            return $urandom_range(7, PAYLOAD_DEPTH - 1);
        return PAYLOAD_DEPTH;
    endfunction

    // Random traffic: mostly good frames, plus bad checksums, oversized
    // lengths, broken sync and line noise.
    task automatic send_random_traffic();
        int unsigned kind;
        kind = $urandom_range(99);
        if (kind < 65)
        begin
            send_frame(8'($urandom), pick_len(), 8'd0);
        end
        else if (kind < 75)
        begin
            send_frame(8'($urandom), pick_len(), 8'($urandom_range(1, 255)));
        end
        else if (kind < 83)
        begin
            // length over the buffer depth: frame dropped, leftovers are noise
            send_byte(SYNC_FIRST);
            send_byte(SYNC_SECOND);
            send_byte(8'($urandom));
            send_byte(8'($urandom_range(PAYLOAD_DEPTH + 1, 255)));
            repeat ($urandom_range(0, 3))
                send_byte(8'($urandom));
        end
        else if (kind < 90)
        begin
            send_byte(SYNC_FIRST);
            send_byte(SYNC_SECOND ^ 8'($urandom_range(1, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                send_byte(8'($urandom));
        end
    endtask

    initial
    begin
        int unsigned phase_end;
        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.rx_byte <= 8'd0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty frame with the lowest type.
        send_frame(8'h00, 0, 8'd0);
        // Wrong second sync byte that is itself a first sync byte: it must not
        // restart the frame, so the following 0x55 is just noise.
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        // All-ones frame: type, payload and checksum all 0xFF.
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(8'hFF);
        // Length one past the buffer depth drops the frame.
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(8'h11);
        send_byte(8'(PAYLOAD_DEPTH + 1));
        // Empty frame with a bad checksum: nothing comes out.
        send_frame(8'h3C, 0, 8'h01);
        drain();

        // Random part in three idle settings, draining between them.
        for (int p = 0; p < 3; p++)
        begin
            if (p == 1)
            begin
                send_idle_pct <= 58;
                recv_idle_pct <= 34;
                @(posedge clk);
            end
            else if (p == 2)
            begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
                @(posedge clk);
                // at least one frame at full buffer depth
                send_frame(8'($urandom), PAYLOAD_DEPTH, 8'd0);
            end
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end)
                send_random_traffic();
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && beats_pending == 0)
            $display("sync_length_checksum_deframer_unit test passed");
        else
            $display("sync_length_checksum_deframer_unit test failed");
        $finish;
    end

endmodule

// File: sync_length_checksum_deframer_unit.f
+incdir+src
src/slcd_pkg.sv
src/slcd_ifs.sv
src/slcd_ctrl.sv
src/slcd_dp.sv
src/sync_length_checksum_deframer_unit.sv
bench/slcd_frame_checker.sv
bench/tb.sv
